>>> sv/lmsl_pkg.sv
// ---------------------------------------------------------------------------
// lmsl_pkg
// shared types and constants of the min-sum ldpc lane
// ---------------------------------------------------------------------------
package lmsl_pkg;

    localparam int NUM_COLUMNS = 68;
    localparam int LLR_BITS    = 8;
    localparam int MAG_W       = LLR_BITS - 1;
    localparam int NODE_W      = $clog2(NUM_COLUMNS);
    localparam int SCALE_W     = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = SCALE_W;

    localparam logic [MAG_W-1:0]   MAG_FULL          = {MAG_W{1'b1}};
    localparam logic [MAG_W-1:0]   LLR_MAX_RESET     = MAG_W'(119);
    localparam logic [MAG_W-1:0]   LLR_INF_RESET     = MAG_W'(127);
    localparam logic [SCALE_W-1:0] SCALE_RESET       = SCALE_W'(205);

    localparam logic [CFG_IDX_W-1:0] CFG_LLR_MAX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LLR_INFINITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd2;

    typedef enum logic [1:0] {
        MODE_V2C  = 2'd0,
        MODE_ACC  = 2'd1,
        MODE_C2V  = 2'd2,
        MODE_SOFT = 2'd3
    } t_mode;

    typedef logic signed [LLR_BITS-1:0] t_llr;

    typedef struct packed {
        t_mode               mode;
        logic                first;
        t_llr                llr_a;
        t_llr                llr_b;
        logic [NODE_W-1:0]   node_index;
    } t_in_beat;

    typedef struct packed {
        t_llr  llr;
        t_mode mode;
    } t_out_beat;

endpackage

>>> sv/lmsl_if.sv
// ---------------------------------------------------------------------------
// lmsl interfaces
// valid/ready channels for input beats, result beats and register writes
// ---------------------------------------------------------------------------
interface lmsl_in_if;
    logic                           valid;
    logic                           ready;
    lmsl_pkg::t_mode                mode;
    logic                           first;
    lmsl_pkg::t_llr                 llr_a;
    lmsl_pkg::t_llr                 llr_b;
    logic [lmsl_pkg::NODE_W-1:0]    node_index;

    modport source (output valid, mode, first, llr_a, llr_b, node_index, input ready);
    modport sink   (input valid, mode, first, llr_a, llr_b, node_index, output ready);
endinterface

interface lmsl_out_if;
    logic                   valid;
    logic                   ready;
    lmsl_pkg::t_llr         result_llr;
    lmsl_pkg::t_mode        result_mode;

    modport source (output valid, result_llr, result_mode, input ready);
    modport sink   (input valid, result_llr, result_mode, output ready);
endinterface

interface lmsl_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lmsl_pkg::CFG_IDX_W-1:0]     index;
    logic [lmsl_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/ldpc_min_sum_lane_core.sv
// ---------------------------------------------------------------------------
// ldpc_min_sum_lane_core
// one lane of a layered normalised min-sum ldpc check-node processor
// ---------------------------------------------------------------------------
// The lane takes one input beat per clock while the input register can move on
// and hands back a result beat: a beat is captured in an input register, worked
// on by one pass of combinational logic (a subtract, an add, or a 7x9
// multiply for the check-to-var scaling) and lands in the result register.
// Accumulate beats (mode 1) update the running minimum statistics as they
// leave the input register and give no result beat; a following emit beat
// (mode 2) already sees the updated statistics. The input side keeps taking
// beats while a result waits to be taken, as long as the input register can
// move on. Register writes take effect at once and are meant for idle times.
// ---------------------------------------------------------------------------
module ldpc_min_sum_lane_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmsl_in_if.sink     i_in,
    lmsl_out_if.source  o_out,
    lmsl_cfg_if.sink    i_cfg
);

    localparam int W = lmsl_pkg::LLR_BITS;
    localparam int MW = lmsl_pkg::MAG_W;
    localparam int SW = lmsl_pkg::SCALE_W;
    localparam int PW = MW + SW;

    // configuration registers
    logic [MW-1:0] r_llr_max;
    logic [MW-1:0] r_llr_inf;
    logic [SW-1:0] r_scale;

    // check-node statistics
    logic [MW-1:0]                  r_small, n_small;
    logic [MW-1:0]                  r_second, n_second;
    logic [lmsl_pkg::NODE_W-1:0]    r_idx, n_idx;
    logic                           r_parity, n_parity;

    // input register and result register
    logic                   r_s1_valid;
    lmsl_pkg::t_in_beat     r_s1;
    logic                   r_out_valid;
    lmsl_pkg::t_out_beat    r_out;

    logic w_in_fire;
    logic w_out_free;
    logic w_s1_adv;
    logic w_s1_emits;

    // datapath
    logic signed [W:0]  w_a9, w_b9, w_mx9, w_inf9;
    logic signed [W:0]  w_diff, w_sum, w_sum_sat, w_res;
    logic               w_c_plus, w_c_minus, w_v_plus, w_v_minus;
    logic [MW-1:0]      w_mag, w_abs_a;
    logic [PW-1:0]      w_prod;
    logic [MW-1:0]      w_scaled;
    logic               w_neg;
    logic [MW-1:0]      w_base_small, w_base_second;
    logic               w_base_parity;

    // ---------------- handshake ----------------
    // accumulate beats never need the result register
    assign w_s1_emits = (r_s1.mode != lmsl_pkg::MODE_ACC);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_adv   = r_s1_valid && (!w_s1_emits || w_out_free);
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_in_fire  = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.result_llr  = r_out.llr;
    assign o_out.result_mode = r_out.mode;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv && w_s1_emits) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1.mode       <= i_in.mode;
            r_s1.first      <= i_in.first;
            r_s1.llr_a      <= i_in.llr_a;
            r_s1.llr_b      <= i_in.llr_b;
            r_s1.node_index <= i_in.node_index;
        end
        if (w_s1_adv && w_s1_emits) begin
            r_out.llr  <= w_res[W-1:0];
            r_out.mode <= r_s1.mode;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_llr_max <= lmsl_pkg::LLR_MAX_RESET;
            r_llr_inf <= lmsl_pkg::LLR_INF_RESET;
            r_scale   <= lmsl_pkg::SCALE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lmsl_pkg::CFG_LLR_MAX:      r_llr_max <= i_cfg.data[MW-1:0];
                lmsl_pkg::CFG_LLR_INFINITY: r_llr_inf <= i_cfg.data[MW-1:0];
                lmsl_pkg::CFG_SCALE_FACTOR: r_scale   <= i_cfg.data[SW-1:0];
                default: ; // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------- datapath ----------------
    // everything worked at llr width plus one so nothing wraps
    assign w_a9   = {r_s1.llr_a[W-1], r_s1.llr_a};
    assign w_b9   = {r_s1.llr_b[W-1], r_s1.llr_b};
    assign w_mx9  = $signed({2'b00, r_llr_max});
    assign w_inf9 = $signed({2'b00, r_llr_inf});

    assign w_diff = w_a9 - w_b9;
    assign w_sum  = w_a9 + w_b9;

    // saturate the sum to the llr range
    always_comb begin
        if (w_sum > $signed({2'b00, {MW{1'b1}}})) begin
            w_sum_sat = $signed({2'b00, {MW{1'b1}}});
        end else if (w_sum < $signed({2'b11, {MW{1'b0}}})) begin
            w_sum_sat = $signed({2'b11, {MW{1'b0}}});
        end else begin
            w_sum_sat = w_sum;
        end
    end

    assign w_c_plus  = w_a9 > w_mx9;
    assign w_c_minus = w_a9 < -w_mx9;
    assign w_v_plus  = w_b9 > w_mx9;
    assign w_v_minus = w_b9 < -w_mx9;

    // check-to-var magnitude: exclude the current column from the minimum
    assign w_mag  = (r_s1.node_index == r_idx) ? r_second : r_small;
    assign w_prod = PW'(w_mag) * PW'(r_scale);
    assign w_scaled = (w_prod[PW-1:8] > {{(PW-8-MW){1'b0}}, r_llr_max})
                      ? r_llr_max : w_prod[8+MW-1:8];
    assign w_neg  = r_s1.llr_a[W-1] ^ r_parity;

    always_comb begin
        w_res = '0;
        unique case (r_s1.mode)
            lmsl_pkg::MODE_V2C: begin
                if (w_diff > w_mx9) begin
                    w_res = w_mx9;
                end else if (w_diff < -w_mx9) begin
                    w_res = -w_mx9;
                end else begin
                    w_res = w_diff;
                end
                if (w_a9 >= w_inf9) begin
                    w_res = w_inf9;
                end
                if (w_a9 <= -w_inf9) begin
                    w_res = -w_inf9;
                end
            end
            lmsl_pkg::MODE_C2V: begin
                w_res = w_neg ? -$signed({2'b00, w_scaled}) : $signed({2'b00, w_scaled});
            end
            lmsl_pkg::MODE_SOFT: begin
                w_res = w_sum_sat;
                // opposite infinities fall through to the plain sum
                if (w_sum_sat > w_mx9 || (w_c_plus && !w_v_minus)
                        || (w_v_plus && !w_c_minus)) begin
                    w_res = w_inf9;
                end
                if (w_res < -w_mx9 || (w_c_minus && !w_v_plus)
                        || (w_v_minus && !w_c_plus)) begin
                    w_res = -w_inf9;
                end
            end
            default: w_res = '0; // accumulate gives no result
        endcase
    end

    // ---------------- minimum statistics ----------------
    // magnitude of llr_a, the most negative code saturates to full scale
    always_comb begin
        if (r_s1.llr_a == $signed({1'b1, {MW{1'b0}}})) begin
            w_abs_a = lmsl_pkg::MAG_FULL;
        end else if (r_s1.llr_a[W-1]) begin
            w_abs_a = MW'(-r_s1.llr_a);
        end else begin
            w_abs_a = r_s1.llr_a[MW-1:0];
        end
    end

    assign w_base_small  = r_s1.first ? lmsl_pkg::MAG_FULL : r_small;
    assign w_base_second = r_s1.first ? lmsl_pkg::MAG_FULL : r_second;
    assign w_base_parity = r_s1.first ? 1'b0 : r_parity;

    always_comb begin
        n_small  = r_small;
        n_second = r_second;
        n_idx    = r_idx;
        n_parity = r_parity;
        if (w_s1_adv && !w_s1_emits) begin
            n_parity = w_base_parity ^ r_s1.llr_a[W-1];
            n_small  = w_base_small;
            n_second = w_base_second;
            n_idx    = r_s1.first ? '0 : r_idx;
            if (w_base_small > w_abs_a) begin
                n_small = w_abs_a;
                n_idx   = r_s1.node_index;
                // old smallest drops to second candidate
                if (w_base_second > w_abs_a) begin
                    n_second = w_base_small;
                end
            end else if (w_base_second > w_abs_a) begin
                n_second = w_abs_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small  <= lmsl_pkg::MAG_FULL;
            r_second <= lmsl_pkg::MAG_FULL;
            r_idx    <= '0;
            r_parity <= 1'b0;
        end else begin
            r_small  <= n_small;
            r_second <= n_second;
            r_idx    <= n_idx;
            r_parity <= n_parity;
        end
    end

    // ---------------- assertions ----------------
    a_min_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_small <= r_second)
        else $error("smallest magnitude above second magnitude");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && w_s1_emits))
        else $error("result beat without an emitting input beat");

    a_c2v_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mode == lmsl_pkg::MODE_C2V)
            |-> (r_out.llr <= $signed({1'b0, r_llr_max})
                 && r_out.llr >= -$signed({1'b0, r_llr_max})))
        else $error("check-to-var magnitude above llr_max");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_in.ready)
        else $error("input stalled with empty input register");

endmodule

>>> test/lmsl_lane_checker.sv
// ---------------------------------------------------------------------------
// lmsl_lane_checker
// watches the lane channels, predicts each result beat and compares it
// ---------------------------------------------------------------------------
module lmsl_lane_checker
    import lmsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    lmsl_in_if      i_in,
    lmsl_out_if     i_out,
    lmsl_cfg_if     i_cfg,
    output int      o_fail_count,
    output int      o_awaited
);

    // register copies
    logic [MAG_W-1:0]   llr_max_q;
    logic [MAG_W-1:0]   llr_inf_q;
    logic [SCALE_W-1:0] scale_q;

    // running check-node statistics
    logic [MAG_W-1:0]   min_mag;
    logic [MAG_W-1:0]   next_mag;
    logic [NODE_W-1:0]  min_node;
    logic               parity;

    t_out_beat          lane_msgs_due[$];
    int                 results_seen;

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d, %s: got %0d, want %0d",
                 results_seen, what, got, want);
        o_fail_count++;
    endtask

    function automatic int clip_llr(input int x);
        if (x > 127) return 127;
        if (x < -128) return -128;
        return x;
    endfunction

    // runs one beat through the lane; accumulate beats only move the statistics
    function automatic void run_lane_op(input t_in_beat beat, output bit gives,
                                        output t_out_beat res);
        int a;
        int b;
        int mx;
        int inf_v;
        int r;
        int mi;
        int scaled;
        logic [MAG_W-1:0] m;
        logic [MAG_W-1:0] cand;
        logic [MAG_W-1:0] mag;
        bit cp, cm, vp, vm;
        a      = int'(beat.llr_a);
        b      = int'(beat.llr_b);
        mx     = int'(llr_max_q);
        inf_v  = int'(llr_inf_q);
        r      = 0;
        gives  = 1'b1;
        case (beat.mode)
            MODE_V2C: begin
                r = clip_llr(a - b);
                if (r < -mx) r = -mx;
                if (r > mx) r = mx;
                if (a >= inf_v) r = inf_v;
                if (a <= -inf_v) r = -inf_v;
            end
            MODE_ACC: begin
                mi = (a < 0) ? -a : a;
                if (mi > 127) mi = 127;
                m = MAG_W'(mi);
                if (beat.first) begin
                    min_mag  = MAG_FULL;
                    next_mag = MAG_FULL;
                    min_node = '0;
                    parity   = 1'b0;
                end
                parity = parity ^ (a < 0);
                if (min_mag > m) begin
                    cand     = min_mag;
                    min_mag  = m;
                    min_node = beat.node_index;
                end else begin
                    cand = m;
                end
                if (next_mag > m) next_mag = cand;
                gives = 1'b0;
            end
            MODE_C2V: begin
                mag    = (beat.node_index == min_node) ? next_mag : min_mag;
                scaled = (int'(mag) * int'(scale_q)) >>> 8;
                if (scaled > mx) scaled = mx;
                r = (((a < 0) ? 1'b1 : 1'b0) ^ parity) ? -scaled : scaled;
            end
            default: begin
                cp = a > mx;
                cm = a < -mx;
                vp = b > mx;
                vm = b < -mx;
                r  = clip_llr(a + b);
                if (r > mx || (cp && !vm) || (vp && !cm)) r = inf_v;
                if (r < -mx || (cm && !vp) || (vm && !cp)) r = -inf_v;
            end
        endcase
        res.llr  = t_llr'(r);
        res.mode = beat.mode;
    endfunction

    always @(posedge i_clk) begin
        t_in_beat   beat;
        t_out_beat  res;
        t_out_beat  want;
        bit         gives;
        if (!i_rst_n) begin
            llr_max_q  = LLR_MAX_RESET;
            llr_inf_q  = LLR_INF_RESET;
            scale_q    = SCALE_RESET;
            min_mag    = MAG_FULL;
            next_mag   = MAG_FULL;
            min_node   = '0;
            parity     = 1'b0;
            lane_msgs_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (lane_msgs_due.size() == 0) begin
                    note_mismatch("unexpected beat, llr", int'(i_out.result_llr), 0);
                end else begin
                    want = lane_msgs_due.pop_front();
                    if (i_out.result_llr !== want.llr)
                        note_mismatch("llr", int'(i_out.result_llr), int'(want.llr));
                    if (i_out.result_mode !== want.mode)
                        note_mismatch("mode", int'(i_out.result_mode), int'(want.mode));
                end
                results_seen++;
            end
            if (i_in.valid && i_in.ready) begin
                beat.mode       = i_in.mode;
                beat.first      = i_in.first;
                beat.llr_a      = i_in.llr_a;
                beat.llr_b      = i_in.llr_b;
                beat.node_index = i_in.node_index;
                run_lane_op(beat, gives, res);
                if (gives) lane_msgs_due.push_back(res);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_LLR_MAX:      llr_max_q = i_cfg.data[MAG_W-1:0];
                    CFG_LLR_INFINITY: llr_inf_q = i_cfg.data[MAG_W-1:0];
                    CFG_SCALE_FACTOR: scale_q   = i_cfg.data[SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_awaited = lane_msgs_due.size();
    end

    initial begin
        o_fail_count = 0;
        o_awaited    = 0;
        results_seen = 0;
    end

endmodule

>>> test/tb_ldpc_min_sum_lane_core.sv
// ---------------------------------------------------------------------------
// tb_ldpc_min_sum_lane_core
// drives the min-sum lane with directed and random beats over several
// register settings; a side checker predicts and compares every result
// ---------------------------------------------------------------------------
module tb_ldpc_min_sum_lane_core;
    import lmsl_pkg::*;

    // cycles allowed for the whole run, far above the slowest clean run
    localparam int CYCLE_LIMIT   = 600000;
    // a beat passes through the input register before it reaches the result register
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 8;
    localparam int BEATS_A_PHASE = 250;

    logic   i_clk = 1'b0;
    logic   i_rst_n;

    lmsl_in_if  in_if ();
    lmsl_out_if out_if ();
    lmsl_cfg_if cfg_if ();

    int     fail_count;
    int     awaited;
    int     cycle_count;
    int     sent_count;
    int     burst_left;
    // register values in force, used to aim llrs at the saturation points
    int     cur_max;
    int     cur_inf;

    // receiver stall pattern, replaced every few rounds
    logic [15:0] ready_pattern;
    logic [5:0]  ready_pos;

    ldpc_min_sum_lane_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    lmsl_lane_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_awaited    (awaited)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a lost result or a hung handshake ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side back-pressure: all ready, random, mostly ready or nearly stuck
    always @(negedge i_clk) begin
        if (ready_pos == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 16'hffff;
                1:       ready_pattern = 16'($urandom);
                2:       ready_pattern = 16'($urandom) | 16'($urandom);
                default: ready_pattern = 16'h0001 << $urandom_range(0, 15);
            endcase
        end
        out_if.ready <= ready_pattern[ready_pos[3:0]];
        ready_pos = ready_pos + 1'b1;
    end

    function automatic t_in_beat mk(input t_mode m, input int f, input int a, input int b,
                                    input int node);
        t_in_beat beat;
        beat.mode       = m;
        beat.first      = f[0];
        beat.llr_a      = t_llr'(a);
        beat.llr_b      = t_llr'(b);
        beat.node_index = NODE_W'(node);
        return beat;
    endfunction

    // llrs weighted towards the full-scale, llr_max and infinity boundaries
    function automatic int pick_llr();
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       v = -128;
                    1:       v = 127;
                    2:       v = -127;
                    3:       v = 0;
                    4:       v = 1;
                    default: v = -1;
                endcase
            end
            1: v = cur_max + $urandom_range(0, 1);
            2: v = cur_inf - $urandom_range(0, 1);
            3: v = $urandom_range(0, 8);
            default: v = int'(t_llr'($urandom_range(0, 255)));
        endcase
        if (v > 127) v = 127;
        if ($urandom_range(0, 1) && v != -128) v = -v;
        return v;
    endfunction

    // mostly real columns, now and then anything the 7-bit field holds
    function automatic int pick_node();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
        return $urandom_range(0, NUM_COLUMNS - 1);
    endfunction

    // one beat onto the input channel, with bursts and random gaps in front
    task automatic send_beat(input t_in_beat beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(8, 20);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_if.valid      <= 1'b1;
        in_if.mode       <= beat.mode;
        in_if.first      <= beat.first;
        in_if.llr_a      <= beat.llr_a;
        in_if.llr_b      <= beat.llr_b;
        in_if.node_index <= beat.node_index;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    // stop feeding and let the lane empty out, accumulate beats included
    task automatic let_lane_settle();
        in_if.valid <= 1'b0;
        while (awaited != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // valid is left high so that back-to-back writes never drop it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
    endtask

    task automatic set_lane_config(input int mx, input int inf_v, input int scale);
        write_reg(CFG_LLR_MAX, mx);
        write_reg(CFG_LLR_INFINITY, inf_v);
        write_reg(CFG_SCALE_FACTOR, scale);
        cfg_if.valid <= 1'b0;
        cur_max = mx;
        cur_inf = inf_v;
    endtask

    // one check row as a layered decoder walks it: var-to-check, fold, emit, soft bit
    task automatic send_row();
        int cols[16];
        int deg;
        int fl;
        deg = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
        for (int i = 0; i < deg; i++) cols[i] = pick_node();
        for (int i = 0; i < deg; i++) begin
            if ($urandom_range(0, 1))
                send_beat(mk(MODE_V2C, $urandom_range(0, 1), pick_llr(), pick_llr(),
                             pick_node()));
            // the first fold clears the row, odd rows go without it (broken row)
            if (i == 0) fl = ($urandom_range(0, 15) != 0);
            else        fl = ($urandom_range(0, 15) == 0);
            send_beat(mk(MODE_ACC, fl, pick_llr(), $urandom_range(0, 255), cols[i]));
        end
        for (int i = 0; i < deg; i++) begin
            send_beat(mk(MODE_C2V, $urandom_range(0, 1), pick_llr(), $urandom_range(0, 255),
                         ($urandom_range(0, 7) == 0) ? pick_node() : cols[i]));
            if ($urandom_range(0, 1))
                send_beat(mk(MODE_SOFT, $urandom_range(0, 1), pick_llr(), pick_llr(),
                             $urandom_range(0, 127)));
        end
    endtask

    // loose beats of any mode with fully random fields
    task automatic send_noise();
        repeat ($urandom_range(1, 5)) begin
            send_beat(mk(t_mode'($urandom_range(0, 3)), $urandom_range(0, 1),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 127)));
        end
    endtask

    initial begin
        int target;
        int mx;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.mode       = MODE_V2C;
        in_if.first      = 1'b0;
        in_if.llr_a      = '0;
        in_if.llr_b      = '0;
        in_if.node_index = '0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_LLR_MAX;
        cfg_if.data      = '0;
        ready_pattern    = 16'hffff;
        ready_pos        = '0;
        cycle_count      = 0;
        sent_count       = 0;
        burst_left       = 0;
        cur_max          = int'(LLR_MAX_RESET);
        cur_inf          = int'(LLR_INF_RESET);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, register values from reset
        // statistics straight out of reset
        send_beat(mk(MODE_C2V, 0, 5, 0, 0));
        // var-to-check: infinite soft inputs, clamping at llr_max, first ignored
        send_beat(mk(MODE_V2C, 0, 127, 0, 0));
        send_beat(mk(MODE_V2C, 0, -128, 0, 0));
        send_beat(mk(MODE_V2C, 1, 100, -100, 0));
        send_beat(mk(MODE_V2C, 0, -100, 100, 0));
        send_beat(mk(MODE_V2C, 0, 5, -128, 0));
        send_beat(mk(MODE_V2C, 0, 0, 0, 127));
        // folding: full-scale negative, new minimum, second minimum, tie
        send_beat(mk(MODE_ACC, 1, -128, 0, 127));
        send_beat(mk(MODE_ACC, 0, 3, 0, 5));
        send_beat(mk(MODE_ACC, 0, -7, 0, 67));
        send_beat(mk(MODE_ACC, 0, 3, 0, 10));
        // emit at the minimum column, elsewhere and at a column out of range
        send_beat(mk(MODE_C2V, 0, 10, 0, 5));
        send_beat(mk(MODE_C2V, 1, -10, 0, 0));
        send_beat(mk(MODE_C2V, 0, -128, 0, 127));
        // a fresh row of one zero-magnitude message
        send_beat(mk(MODE_ACC, 1, 0, 0, 0));
        send_beat(mk(MODE_C2V, 0, 0, 0, 0));
        send_beat(mk(MODE_C2V, 0, -1, 0, 1));
        // soft bit: both infinite, opposite infinities, sums past llr_max
        send_beat(mk(MODE_SOFT, 0, 127, 127, 0));
        send_beat(mk(MODE_SOFT, 0, -128, -128, 0));
        send_beat(mk(MODE_SOFT, 0, 127, -128, 0));
        send_beat(mk(MODE_SOFT, 0, 60, 60, 0));
        send_beat(mk(MODE_SOFT, 0, -60, -59, 0));
        send_beat(mk(MODE_SOFT, 1, 120, -5, 0));
        send_beat(mk(MODE_SOFT, 0, 0, 0, 0));

        // random part, one register setting per phase
        for (int p = 0; p < PHASES; p++) begin
            let_lane_settle();
            case (p)
                0: set_lane_config(1, 2, 0);
                1: set_lane_config(126, 127, 256);
                2: set_lane_config(119, 127, 511);
                3: set_lane_config(63, 64, 128);
                default: begin
                    mx = $urandom_range(1, 126);
                    set_lane_config(mx, $urandom_range(mx + 1, 127),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(257, 511)
                                                                : $urandom_range(0, 256));
                end
            endcase
            target = sent_count + BEATS_A_PHASE;
            while (sent_count < target) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: send_row();
                    7, 8:                send_noise();
                    default: begin
                        send_beat(mk(MODE_V2C, 0, pick_llr(), pick_llr(), pick_node()));
                        send_beat(mk(MODE_SOFT, 0, pick_llr(), pick_llr(), pick_node()));
                    end
                endcase
            end
        end

        let_lane_settle();
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
